// ===== hw/rtl/adsr_pkg.sv =====
package adsr_pkg;

  // Fixed field widths
  localparam int unsigned KIND_W  = 2;
  localparam int unsigned DELTA_W = 16;
  localparam int unsigned STEP_W  = 4;

  // Item kinds
  typedef enum logic [KIND_W-1:0] {
    KIND_TICK     = 2'd0,
    KIND_GATE_ON  = 2'd1,
    KIND_GATE_OFF = 2'd2
  } kind_e;

  // Envelope phases
  typedef enum logic [2:0] {
    PH_IDLE    = 3'd0,
    PH_ATTACK  = 3'd1,
    PH_DECAY   = 3'd2,
    PH_SUSTAIN = 3'd3,
    PH_RELEASE = 3'd4
  } phase_e;

  // Configuration register indexes
  typedef enum logic [1:0] {
    CFG_ATTACK  = 2'd0,
    CFG_DECAY   = 2'd1,
    CFG_SUSTAIN = 2'd2,
    CFG_RELEASE = 2'd3
  } cfg_reg_e;

  // Datapath operations, one per microcode step
  typedef enum logic [3:0] {
    OP_NOP    = 4'd0,
    OP_LOAD   = 4'd1,
    OP_ADD    = 4'd2,
    OP_ATK    = 4'd3,
    OP_DEC    = 4'd4,
    OP_SUS    = 4'd5,
    OP_REL    = 4'd6,
    OP_CLR    = 4'd7,
    OP_GATE   = 4'd8,
    OP_DSET_T = 4'd9,
    OP_DSET_R = 4'd10,
    OP_DIV    = 4'd11,
    OP_DFIN   = 4'd12,
    OP_EMIT   = 4'd13
  } op_e;

  // Jump conditions
  typedef enum logic [3:0] {
    C_NEVER    = 4'd0,
    C_ALWAYS   = 4'd1,
    C_NO_INPUT = 4'd2,
    C_NOT_TICK = 4'd3,
    C_ATK_DIV  = 4'd4,
    C_DEC_DIV  = 4'd5,
    C_SUSTAIN  = 4'd6,
    C_REL_DIV  = 4'd7,
    C_DIV_BUSY = 4'd8,
    C_OUT_FREE = 4'd9
  } cond_e;

  typedef struct packed {
    op_e               op;
    cond_e             cond;
    logic [STEP_W-1:0] target;
  } uword_t;

  // Status flags from the datapath to the sequencer
  typedef struct packed {
    logic in_valid;
    logic not_tick;
    logic atk_div;
    logic dec_div;
    logic sustain;
    logic rel_div;
    logic div_busy;
    logic out_free;
  } adsr_stat_t;

  // Step addresses
  localparam logic [STEP_W-1:0] S_FETCH  = 4'd0;
  localparam logic [STEP_W-1:0] S_GATE   = 4'd8;
  localparam logic [STEP_W-1:0] S_DSET_T = 4'd9;
  localparam logic [STEP_W-1:0] S_DIV    = 4'd11;
  localparam logic [STEP_W-1:0] S_EMIT   = 4'd13;
  localparam logic [STEP_W-1:0] S_DSET_R = 4'd10;

  // Microcode ROM: jump to target when cond holds, else fall through
  function automatic uword_t adsr_rom(input logic [STEP_W-1:0] step);
    uword_t w;
    unique case (step)
      4'd0:    w = '{OP_LOAD,   C_NO_INPUT, S_FETCH};
      4'd1:    w = '{OP_ADD,    C_NOT_TICK, S_GATE};
      4'd2:    w = '{OP_ATK,    C_ATK_DIV,  S_DSET_T};
      4'd3:    w = '{OP_ADD,    C_NEVER,    S_FETCH};
      4'd4:    w = '{OP_DEC,    C_DEC_DIV,  S_DSET_T};
      4'd5:    w = '{OP_SUS,    C_SUSTAIN,  S_EMIT};
      4'd6:    w = '{OP_REL,    C_REL_DIV,  S_DSET_R};
      4'd7:    w = '{OP_CLR,    C_ALWAYS,   S_EMIT};
      4'd8:    w = '{OP_GATE,   C_ALWAYS,   S_EMIT};
      4'd9:    w = '{OP_DSET_T, C_ALWAYS,   S_DIV};
      4'd10:   w = '{OP_DSET_R, C_NEVER,    S_FETCH};
      4'd11:   w = '{OP_DIV,    C_DIV_BUSY, S_DIV};
      4'd12:   w = '{OP_DFIN,   C_ALWAYS,   S_EMIT};
      4'd13:   w = '{OP_EMIT,   C_OUT_FREE, S_FETCH};
      4'd14:   w = '{OP_NOP,    C_ALWAYS,   S_EMIT};
      default: w = '{OP_NOP,    C_ALWAYS,   S_FETCH};
    endcase
    return w;
  endfunction

endpackage

// ===== hw/rtl/adsr_seq.sv =====
module adsr_seq
  import adsr_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  adsr_stat_t stat_i,
  output op_e        op_o
);

  logic [STEP_W-1:0] pc_q, pc_d;
  uword_t            uw;
  logic              taken;

  // Control word fetch
  assign uw   = adsr_rom(pc_q);
  assign op_o = uw.op;

  // Condition select
  always_comb begin
    unique case (uw.cond)
      C_NEVER:    taken = 1'b0;
      C_ALWAYS:   taken = 1'b1;
      C_NO_INPUT: taken = !stat_i.in_valid;
      C_NOT_TICK: taken = stat_i.not_tick;
      C_ATK_DIV:  taken = stat_i.atk_div;
      C_DEC_DIV:  taken = stat_i.dec_div;
      C_SUSTAIN:  taken = stat_i.sustain;
      C_REL_DIV:  taken = stat_i.rel_div;
      C_DIV_BUSY: taken = stat_i.div_busy;
      C_OUT_FREE: taken = stat_i.out_free;
      default:    taken = 1'b0;
    endcase
  end

  // Next step
  assign pc_d = taken ? uw.target : pc_q + STEP_W'(1);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pc_q <= S_FETCH;
    end else begin
      pc_q <= pc_d;
    end
  end

endmodule

// ===== hw/rtl/adsr_envelope_generator_unit.sv =====
// Channel  | Handshake               | Payload
// ---------+-------------------------+--------------------------------------
// in       | in_valid_i/in_stall_o   | kind_i, delta_t_i
// out      | out_valid_o/out_stall_i | level_o, active_o
// cfg      | cfg_we_i                | cfg_index_i, cfg_data_i
//
// Gate events, sustain ticks and ticks that divide take different step paths;
// the divide path is the longest, as the restoring divider retires one
// quotient bit per step.
// Reset sets the envelope idle and the configuration registers to defaults.
// A finished word waits in the output register; the next input word is taken
// meanwhile, and only the emit step waits for out_stall_i to drop.
module adsr_envelope_generator_unit
  import adsr_pkg::*;
#(
  parameter int unsigned TIME_WIDTH      = 24,
  parameter int unsigned LEVEL_FRAC_BITS = 15,
  localparam int unsigned LW   = LEVEL_FRAC_BITS + 1,
  localparam int unsigned CFGW = (TIME_WIDTH > LW) ? TIME_WIDTH : LW
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  logic [KIND_W-1:0]    kind_i,
  input  logic [DELTA_W-1:0]   delta_t_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output logic [LW-1:0]        level_o,
  output logic                 active_o,
  input  logic                 cfg_we_i,
  input  logic [1:0]           cfg_index_i,
  input  logic [CFGW-1:0]      cfg_data_i
);

  localparam int unsigned TW   = TIME_WIDTH;
  localparam int unsigned QB   = LW;
  localparam int unsigned DVW  = (TW + 1 > DELTA_W) ? TW + 1 : DELTA_W;
  localparam int unsigned CNTW = $clog2(QB + 1);
  localparam logic [LW-1:0] FULL = {1'b1, {LEVEL_FRAC_BITS{1'b0}}};

  // Configuration registers
  logic [TW-1:0] atk_q, dec_q, rel_q;
  logic [LW-1:0] sus_q;

  // Envelope state and item
  phase_e             phase_q, phase_d;
  logic [TW:0]        ptime_q, ptime_d;
  logic [LW-1:0]      level_q, level_d;
  kind_e              kind_q, kind_d;
  logic [DELTA_W-1:0] dt_q, dt_d;
  logic [TW:0]        sum_q, sum_d;

  // Divider
  logic [TW-1:0]   dvs_q, dvs_d, rem_q, rem_d;
  logic [QB-1:0]   low_q, low_d;
  logic            ovf_q, ovf_d;
  logic [CNTW-1:0] cnt_q, cnt_d;

  // Output register
  logic          out_valid_q, out_valid_d;
  logic [LW-1:0] out_level_q, out_level_d;
  logic          out_active_q, out_active_d;

  op_e        op;
  adsr_stat_t stat;

  logic [DVW:0]    sum_full;
  logic [LW-1:0]   sus_lim;
  logic            atk_end, dec_end, rel_end;
  logic [DVW-1:0]  num;
  logic [TW-1:0]   dvs_sel;
  logic [TW:0]     r2, diff;
  logic            ge;
  logic [LW-1:0]   dec_v;

  adsr_seq u_seq (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .stat_i (stat),
    .op_o   (op)
  );

  // Saturating time sum
  assign sum_full = (DVW + 1)'(ptime_q) + (DVW + 1)'(dt_q);
  always_comb begin
    if (sum_full > (DVW + 1)'({(TW + 1){1'b1}})) begin
      sum_d = {(TW + 1){1'b1}};
    end else begin
      sum_d = sum_full[TW:0];
    end
  end

  assign sus_lim = (sus_q > FULL) ? FULL : sus_q;

  // Phase end tests
  assign atk_end = (atk_q == '0) || (sum_q > {1'b0, atk_q});
  assign dec_end = (dec_q == '0) || (sum_q > {1'b0, dec_q});
  assign rel_end = (rel_q == '0) || (sum_q > {1'b0, rel_q});

  // Status to the sequencer
  always_comb begin
    stat.in_valid = in_valid_i;
    stat.not_tick = (kind_q != KIND_TICK);
    stat.atk_div  = (phase_q == PH_ATTACK) && !atk_end;
    stat.dec_div  = (phase_q == PH_DECAY) && !dec_end;
    stat.sustain  = (phase_q == PH_SUSTAIN);
    stat.rel_div  = (phase_q == PH_RELEASE) && !rel_end;
    stat.div_busy = (cnt_q != CNTW'(1));
    stat.out_free = !out_valid_q || !out_stall_i;
  end

  // Divider setup operands and one restoring step
  assign num     = (op == OP_DSET_R) ? DVW'(dt_q) : DVW'(sum_q);
  assign dvs_sel = (op == OP_DSET_R) ? rel_q : ((phase_q == PH_ATTACK) ? atk_q : dec_q);
  assign r2      = {rem_q, low_q[QB-1]};
  assign diff    = r2 - {1'b0, dvs_q};
  assign ge      = (r2 >= {1'b0, dvs_q});
  assign dec_v   = FULL - low_q;

  // Datapath operations
  always_comb begin
    phase_d      = phase_q;
    ptime_d      = ptime_q;
    level_d      = level_q;
    kind_d       = kind_q;
    dt_d         = dt_q;
    dvs_d        = dvs_q;
    rem_d        = rem_q;
    low_d        = low_q;
    ovf_d        = ovf_q;
    cnt_d        = cnt_q;
    out_valid_d  = out_valid_q && out_stall_i;
    out_level_d  = out_level_q;
    out_active_d = out_active_q;
    unique case (op)
      OP_LOAD: begin
        kind_d = kind_e'(kind_i);
        dt_d   = delta_t_i;
      end
      OP_ATK: begin
        if (phase_q == PH_ATTACK && atk_end) begin
          ptime_d = sum_q - {1'b0, atk_q};
          phase_d = PH_DECAY;
          dt_d    = '0;
        end
      end
      OP_DEC: begin
        if (phase_q == PH_DECAY && dec_end) begin
          ptime_d = sum_q - {1'b0, dec_q};
          phase_d = PH_SUSTAIN;
        end
      end
      OP_SUS: begin
        if (phase_q == PH_SUSTAIN) begin
          level_d = sus_lim;
        end
      end
      OP_REL: begin
        if (phase_q == PH_RELEASE && rel_end) begin
          level_d = '0;
          phase_d = PH_IDLE;
        end
      end
      OP_CLR: begin
        level_d = '0;
      end
      OP_GATE: begin
        unique case (kind_q)
          KIND_GATE_ON: begin
            ptime_d = '0;
            level_d = '0;
            phase_d = PH_ATTACK;
          end
          KIND_GATE_OFF: begin
            ptime_d = '0;
            if (phase_q != PH_IDLE) begin
              phase_d = PH_RELEASE;
            end
          end
          default: ;
        endcase
      end
      OP_DSET_T, OP_DSET_R: begin
        if (op == OP_DSET_T) begin
          ptime_d = sum_q;
        end
        dvs_d = dvs_sel;
        ovf_d = (num[DVW-1:1] >= (DVW - 1)'(dvs_sel));
        rem_d = num[TW:1];
        low_d = {num[0], {LEVEL_FRAC_BITS{1'b0}}};
        cnt_d = CNTW'(QB);
      end
      OP_DIV: begin
        rem_d = ge ? diff[TW-1:0] : r2[TW-1:0];
        low_d = {low_q[QB-2:0], ge};
        cnt_d = cnt_q - CNTW'(1);
      end
      OP_DFIN: begin
        unique case (phase_q)
          PH_ATTACK: level_d = low_q;
          PH_DECAY: begin
            if (dec_v < sus_lim) begin
              phase_d = PH_SUSTAIN;
              level_d = sus_lim;
            end else begin
              level_d = dec_v;
            end
          end
          PH_RELEASE: begin
            if (ovf_q || (level_q < low_q)) begin
              level_d = '0;
              phase_d = PH_IDLE;
            end else begin
              ptime_d = sum_q;
              level_d = level_q - low_q;
            end
          end
          default: ;
        endcase
      end
      OP_EMIT: begin
        if (stat.out_free) begin
          out_valid_d  = 1'b1;
          out_level_d  = level_q;
          out_active_d = (phase_q != PH_IDLE);
        end
      end
      default: ;
    endcase
  end

  // Control and envelope state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PH_IDLE;
      ptime_q     <= '0;
      level_q     <= '0;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
      atk_q       <= '0;
      dec_q       <= '0;
      rel_q       <= '0;
      sus_q       <= FULL;
    end else begin
      phase_q     <= phase_d;
      ptime_q     <= ptime_d;
      level_q     <= level_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
      if (cfg_we_i) begin
        unique case (cfg_reg_e'(cfg_index_i))
          CFG_ATTACK:  atk_q <= cfg_data_i[TW-1:0];
          CFG_DECAY:   dec_q <= cfg_data_i[TW-1:0];
          CFG_SUSTAIN: sus_q <= cfg_data_i[LW-1:0];
          CFG_RELEASE: rel_q <= cfg_data_i[TW-1:0];
          default: ;
        endcase
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    kind_q       <= kind_d;
    dt_q         <= dt_d;
    if (op == OP_ADD) begin
      sum_q <= sum_d;
    end
    dvs_q        <= dvs_d;
    rem_q        <= rem_d;
    low_q        <= low_d;
    ovf_q        <= ovf_d;
    out_level_q  <= out_level_d;
    out_active_q <= out_active_d;
  end

  assign in_stall_o  = (op != OP_LOAD);
  assign out_valid_o = out_valid_q;
  assign level_o     = out_level_q;
  assign active_o    = out_active_q;

endmodule
